FILE: src/swff_pkg.sv
// Package: payload structs and codes for the shallow-water face flux accumulator.
`default_nettype none
package swff_pkg;

	localparam int unsigned RES_W  = 32;
	localparam int unsigned CELL_W = 12;
	localparam int unsigned GRAV_W = 31;
	localparam int unsigned STRD_W = 13;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_IFACE = 2'd1;
	localparam logic [1:0] MODE_JFACE = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	localparam logic CFG_GRAVITY = 1'b0;
	localparam logic CFG_STRIDE = 1'b1;

	typedef struct packed {
		logic [1:0]              mode;
		logic [CELL_W-1:0]       cell_index;
		logic signed [RES_W-1:0] depth_left;
		logic signed [RES_W-1:0] xmom_left;
		logic signed [RES_W-1:0] ymom_left;
		logic signed [RES_W-1:0] depth_right;
		logic signed [RES_W-1:0] xmom_right;
		logic signed [RES_W-1:0] ymom_right;
		logic signed [RES_W-1:0] normal_x;
		logic signed [RES_W-1:0] normal_y;
	} in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] res_mass;
		logic signed [RES_W-1:0] res_xmom;
		logic signed [RES_W-1:0] res_ymom;
		logic [1:0]              status;
	} out_t;

endpackage
`default_nettype wire

FILE: src/shallow_water_face_flux_accumulator.sv
// Top level: per-cell residual store with central convective face flux.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------
//  in      | input     | in_valid/in_stall  | swff_pkg::in_t
//  out     | output    | out_valid/out_stall| swff_pkg::out_t
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item at a time. Init, read and zero-depth faces skip the arithmetic; a face
// makes eleven passes through the shared 33x33 multiplier plus a 32-step
// restoring divider for the normal velocity, then a read-modify-write of the
// cell and one of its neighbour, if it has one.
// Residuals live in one 96-bit RAM, undefined until written; no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset is asynchronous, clears control state and the datapath registers, and loads the default gravity and stride.
`default_nettype none
module shallow_water_face_flux_accumulator #(
	parameter int GRID_CELLS = 4096,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire swff_pkg::in_t               in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output swff_pkg::out_t                   out_data,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [swff_pkg::GRAV_W-1:0] cfg_data
);
	import swff_pkg::*;

	localparam int AW = $clog2(GRID_CELLS);
	localparam int MW = 3 * RES_W;
	localparam int TW = 62 - FRAC_BITS;
	localparam int TL = (TW + 1) / 2;
	localparam int GW = 31 + TW;
	localparam int FW = 66 - FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_AVG = 4'd1;
	localparam logic [3:0] ST_MULA = 4'd2;
	localparam logic [3:0] ST_MULB = 4'd3;
	localparam logic [3:0] ST_NUM = 4'd4;
	localparam logic [3:0] ST_DIVS = 4'd5;
	localparam logic [3:0] ST_DIV = 4'd6;
	localparam logic [3:0] ST_VC = 4'd7;
	localparam logic [3:0] ST_GHV = 4'd8;
	localparam logic [3:0] ST_FLX = 4'd9;
	localparam logic [3:0] ST_CWR = 4'd10;
	localparam logic [3:0] ST_NRD = 4'd11;
	localparam logic [3:0] ST_NWR = 4'd12;
	localparam logic [3:0] ST_RDW = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	localparam logic [3:0] OP_HUNX = 4'd0;
	localparam logic [3:0] OP_HVNY = 4'd1;
	localparam logic [3:0] OP_HLSQ = 4'd2;
	localparam logic [3:0] OP_HRSQ = 4'd3;
	localparam logic [3:0] OP_GTL = 4'd4;
	localparam logic [3:0] OP_GTH = 4'd5;
	localparam logic [3:0] OP_VHA = 4'd6;
	localparam logic [3:0] OP_VHU = 4'd7;
	localparam logic [3:0] OP_GNX = 4'd8;
	localparam logic [3:0] OP_VHV = 4'd9;
	localparam logic [3:0] OP_GNY = 4'd10;

	localparam logic signed [RES_W-1:0] SMAX = 32'sh7FFFFFFF;
	localparam logic signed [RES_W-1:0] SMIN = 32'sh80000000;

	// saturate to 32-bit signed, flag in the top bit
	function automatic logic [32:0] sat32(input logic signed [71:0] x);
		if (x > 72'sh7FFFFFFF) begin
			sat32 = {1'b1, SMAX};
		end else if (x < -72'sh80000000) begin
			sat32 = {1'b1, SMIN};
		end else begin
			sat32 = {1'b0, x[31:0]};
		end
	endfunction

	logic [3:0]              st_q;
	in_t                     it_q;
	logic [GRAV_W-1:0]       gravity_q;
	logic [STRD_W-1:0]       stride_q;
	logic signed [31:0]      ha_q, hua_q, hva_q;
	logic [3:0]              mop_q;
	logic signed [65:0]      prod_q;
	logic signed [63:0]      p1_q, p2_q;
	logic [63:0]             sq_q;
	logic [GW-1:0]           gp_q;
	logic signed [FW-1:0]    f0_q, f1_q, f2_q;
	logic signed [31:0]      ghavg_q, vcont_q;
	logic signed [64:0]      num_q;
	logic [31:0]             dvs_q, rem_q, dvd_q;
	logic                    qneg_q, dovf_q;
	logic [4:0]              cnt_q;
	logic signed [31:0]      c0_q, c1_q, c2_q;
	logic                    sat_q, ha0_q;
	logic signed [31:0]      rm_q, rx_q, ry_q;
	logic                    out_vld_q;
	out_t                    out_q;

	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [MW-1:0]           ram_wdata, ram_rdata;

	logic signed [32:0]      hs_c, hus_c, hvs_c;
	logic signed [31:0]      ha_c;
	logic                    inr_c;
	logic [AW-1:0]           cell_c;
	logic [STRD_W-1:0]       off_c, nb13_c;
	logic                    nbv_c;
	logic [AW-1:0]           nb_c;
	logic [32:0]             im_c, ix_c, iy_c;
	logic signed [31:0]      mm_c, mx_c, my_c;
	logic [32:0]             sm_c, sx_c, sy_c;
	logic [32:0]             nm_c, nx_c, ny_c;
	logic signed [32:0]      opa_c, opb_c;
	logic [TW-1:0]           t_c;
	logic [63:0]             mag_c;
	logic [31:0]             dm_c;
	logic [32:0]             rem2_c;
	logic                    ge_c;
	logic                    out_ld;
	logic [32:0]             k0_c, k1_c, k2_c;

	swff_ram #(.WIDTH(MW), .DEPTH(GRID_CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// averages, range and neighbour
	always_comb begin
		hs_c = 33'(it_q.depth_left) + 33'(it_q.depth_right);
		hus_c = 33'(it_q.xmom_left) + 33'(it_q.xmom_right);
		hvs_c = 33'(it_q.ymom_left) + 33'(it_q.ymom_right);
		ha_c = hs_c[32:1];
		inr_c = 32'(it_q.cell_index) < 32'(GRID_CELLS);
		cell_c = AW'(it_q.cell_index);
		off_c = (it_q.mode == MODE_IFACE) ? STRD_W'(1) : stride_q;
		nbv_c = STRD_W'(it_q.cell_index) >= off_c;
		nb13_c = STRD_W'(it_q.cell_index) - off_c;
		nb_c = AW'(nb13_c);
		im_c = sat32(-72'(it_q.depth_right));
		ix_c = sat32(-72'(it_q.xmom_right));
		iy_c = sat32(-72'(it_q.ymom_right));
		mm_c = ram_rdata[3*RES_W-1:2*RES_W];
		mx_c = ram_rdata[2*RES_W-1:RES_W];
		my_c = ram_rdata[RES_W-1:0];
		sm_c = sat32(72'(mm_c) + 72'(c0_q));
		sx_c = sat32(72'(mx_c) + 72'(c1_q));
		sy_c = sat32(72'(my_c) + 72'(c2_q));
		nm_c = sat32(72'(mm_c) - 72'(c0_q));
		nx_c = sat32(72'(mx_c) - 72'(c1_q));
		ny_c = sat32(72'(my_c) - 72'(c2_q));
		k0_c = sat32(72'(f0_q));
		k1_c = sat32(72'(f1_q));
		k2_c = sat32(72'(f2_q));
	end

	// shared multiplier operand select
	always_comb begin
		t_c = sq_q[63:FRAC_BITS+2];
		case (mop_q)
			OP_HUNX: begin opa_c = 33'(hua_q); opb_c = 33'(it_q.normal_x); end
			OP_HVNY: begin opa_c = 33'(hva_q); opb_c = 33'(it_q.normal_y); end
			OP_HLSQ: begin opa_c = 33'(it_q.depth_left); opb_c = 33'(it_q.depth_left); end
			OP_HRSQ: begin opa_c = 33'(it_q.depth_right); opb_c = 33'(it_q.depth_right); end
			OP_GTL: begin
				opa_c = $signed({2'b00, gravity_q});
				opb_c = $signed(33'(t_c[TL-1:0]));
			end
			OP_GTH: begin
				opa_c = $signed({2'b00, gravity_q});
				opb_c = $signed(33'(t_c[TW-1:TL]));
			end
			OP_VHA: begin opa_c = 33'(vcont_q); opb_c = 33'(ha_q); end
			OP_VHU: begin opa_c = 33'(vcont_q); opb_c = 33'(hua_q); end
			OP_GNX: begin opa_c = 33'(ghavg_q); opb_c = 33'(it_q.normal_x); end
			OP_VHV: begin opa_c = 33'(vcont_q); opb_c = 33'(hva_q); end
			OP_GNY: begin opa_c = 33'(ghavg_q); opb_c = 33'(it_q.normal_y); end
			default: begin opa_c = '0; opb_c = '0; end
		endcase
	end

	// divider setup and step
	always_comb begin
		mag_c = num_q[64] ? 64'(-num_q) : num_q[63:0];
		dm_c = ha_q[31] ? (~ha_q + 32'd1) : ha_q;
		rem2_c = {rem_q, dvd_q[31]};
		ge_c = rem2_c >= {1'b0, dvs_q};
	end

	// memory port control
	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = cell_c;
		ram_raddr = cell_c;
		ram_wdata = {sm_c[31:0], sx_c[31:0], sy_c[31:0]};
		case (st_q)
			ST_AVG: begin
				if (inr_c) begin
					if (it_q.mode == MODE_INIT) begin
						ram_we = 1'b1;
						ram_wdata = {im_c[31:0], ix_c[31:0], iy_c[31:0]};
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_CWR: ram_we = 1'b1;
			ST_NRD: begin
				ram_re = 1'b1;
				ram_raddr = nb_c;
			end
			ST_NWR: begin
				ram_we = 1'b1;
				ram_waddr = nb_c;
				ram_wdata = {nm_c[31:0], nx_c[31:0], ny_c[31:0]};
			end
			default: ;
		endcase
	end

	assign in_stall = (st_q != ST_IDLE);
	assign out_ld = (st_q == ST_OUT) && (!out_vld_q || !out_stall);
	assign out_valid = out_vld_q;
	assign out_data = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAV_W'(642908);
			stride_q <= STRD_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAVITY: gravity_q <= cfg_data;
				CFG_STRIDE: stride_q <= cfg_data[STRD_W-1:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else if (out_ld) begin
			out_vld_q <= 1'b1;
			out_q.res_mass <= rm_q;
			out_q.res_xmom <= rx_q;
			out_q.res_ymom <= ry_q;
			out_q.status <= ha0_q ? STAT_ZERO : (sat_q ? STAT_SAT : STAT_OK);
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			it_q <= '0;
			ha_q <= '0; hua_q <= '0; hva_q <= '0;
			mop_q <= OP_HUNX;
			prod_q <= '0;
			p1_q <= '0; p2_q <= '0; sq_q <= '0; gp_q <= '0;
			f0_q <= '0; f1_q <= '0; f2_q <= '0;
			ghavg_q <= '0; vcont_q <= '0; num_q <= '0;
			dvs_q <= '0; rem_q <= '0; dvd_q <= '0;
			qneg_q <= 1'b0; dovf_q <= 1'b0; cnt_q <= '0;
			c0_q <= '0; c1_q <= '0; c2_q <= '0;
			sat_q <= 1'b0; ha0_q <= 1'b0;
			rm_q <= '0; rx_q <= '0; ry_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						it_q <= in_data;
						sat_q <= 1'b0;
						ha0_q <= 1'b0;
						st_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					ha_q <= ha_c;
					hua_q <= hus_c[32:1];
					hva_q <= hvs_c[32:1];
					mop_q <= OP_HUNX;
					if (!inr_c) begin
						rm_q <= '0; rx_q <= '0; ry_q <= '0;
						st_q <= ST_OUT;
					end else if (it_q.mode == MODE_INIT) begin
						rm_q <= im_c[31:0]; rx_q <= ix_c[31:0]; ry_q <= iy_c[31:0];
						sat_q <= im_c[32] | ix_c[32] | iy_c[32];
						st_q <= ST_OUT;
					end else if (it_q.mode == MODE_READ || ha_c == '0) begin
						ha0_q <= (it_q.mode != MODE_READ);
						st_q <= ST_RDW;
					end else begin
						st_q <= ST_MULA;
					end
				end
				ST_RDW: begin
					rm_q <= mm_c; rx_q <= mx_c; ry_q <= my_c;
					st_q <= ST_OUT;
				end
				ST_MULA: begin
					prod_q <= opa_c * opb_c;
					st_q <= ST_MULB;
				end
				ST_MULB: begin
					mop_q <= mop_q + 4'd1;
					st_q <= ST_MULA;
					case (mop_q)
						OP_HUNX: p1_q <= prod_q[63:0];
						OP_HVNY: begin
							p2_q <= prod_q[63:0];
							st_q <= ST_NUM;
						end
						OP_HLSQ: sq_q <= prod_q[63:0];
						OP_HRSQ: sq_q <= sq_q + prod_q[63:0];
						OP_GTL: gp_q <= GW'(prod_q[63:0]);
						OP_GTH: begin
							gp_q <= gp_q + (GW'(prod_q[63:0]) << TL);
							st_q <= ST_GHV;
						end
						OP_VHA: f0_q <= FW'(prod_q >>> FRAC_BITS);
						OP_VHU: f1_q <= FW'(prod_q >>> FRAC_BITS);
						OP_GNX: f1_q <= f1_q + FW'(prod_q >>> FRAC_BITS);
						OP_VHV: f2_q <= FW'(prod_q >>> FRAC_BITS);
						OP_GNY: begin
							f2_q <= f2_q + FW'(prod_q >>> FRAC_BITS);
							st_q <= ST_FLX;
						end
						default: st_q <= ST_FLX;
					endcase
				end
				ST_NUM: begin
					num_q <= 65'(p1_q) + 65'(p2_q);
					st_q <= ST_DIVS;
				end
				ST_DIVS: begin
					dvs_q <= dm_c;
					rem_q <= mag_c[63:32];
					dvd_q <= mag_c[31:0];
					dovf_q <= mag_c[63:32] >= dm_c;
					qneg_q <= num_q[64] ^ ha_q[31];
					cnt_q <= '0;
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge_c ? 32'(rem2_c - {1'b0, dvs_q}) : rem2_c[31:0];
					dvd_q <= {dvd_q[30:0], ge_c};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						st_q <= ST_VC;
					end
				end
				ST_VC: begin
					// clamp the quotient to the signed range
					if (!qneg_q) begin
						if (dovf_q || dvd_q > 32'h7FFFFFFF) begin
							vcont_q <= SMAX;
							sat_q <= 1'b1;
						end else begin
							vcont_q <= dvd_q;
						end
					end else begin
						if (dovf_q || dvd_q > 32'h80000000) begin
							vcont_q <= SMIN;
							sat_q <= 1'b1;
						end else begin
							vcont_q <= -dvd_q;
						end
					end
					mop_q <= OP_HLSQ;
					st_q <= ST_MULA;
				end
				ST_GHV: begin
					if (|gp_q[GW-1:31+FRAC_BITS]) begin
						ghavg_q <= SMAX;
						sat_q <= 1'b1;
					end else begin
						ghavg_q <= {1'b0, gp_q[30+FRAC_BITS:FRAC_BITS]};
					end
					mop_q <= OP_VHA;
					st_q <= ST_MULA;
				end
				ST_FLX: begin
					c0_q <= k0_c[31:0];
					c1_q <= k1_c[31:0];
					c2_q <= k2_c[31:0];
					sat_q <= sat_q | k0_c[32] | k1_c[32] | k2_c[32];
					st_q <= ST_CWR;
				end
				ST_CWR: begin
					rm_q <= sm_c[31:0]; rx_q <= sx_c[31:0]; ry_q <= sy_c[31:0];
					sat_q <= sat_q | sm_c[32] | sx_c[32] | sy_c[32];
					st_q <= nbv_c ? ST_NRD : ST_OUT;
				end
				ST_NRD: st_q <= ST_NWR;
				ST_NWR: begin
					// neighbour is the cell itself when the stride is zero
					if (off_c == '0) begin
						rm_q <= nm_c[31:0]; rx_q <= nx_c[31:0]; ry_q <= ny_c[31:0];
					end
					sat_q <= sat_q | nm_c[32] | nx_c[32] | ny_c[32];
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ld) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (st_q == ST_AVG || st_q == ST_CWR || st_q == ST_NWR))
		else $error("residual write outside a write state");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (st_q == ST_DIV))
		else $error("divider count active outside divide");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_ZERO ||
			out_data.status == STAT_SAT))
		else $error("illegal status code");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st_q == ST_AVG))
		else $error("accepted transfer did not start processing");
endmodule
`default_nettype wire

FILE: src/swff_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module swff_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
